### design/fta_pkg.sv
package fta_pkg;

    localparam int DEFAULT_MAX_FRAMES = 256;
    localparam int DEFAULT_PAGE_BITS  = 20;
    localparam int DEFAULT_SLOT_BITS  = 10;
    localparam int RESET_FRAMES       = 256;

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_MAP   = 2'd1,
        CMD_FREE  = 2'd2,
        CMD_QUERY = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_NO_FREE      = 3'd1,
        ST_RANGE        = 3'd2,
        ST_ALREADY_FREE = 3'd3,
        ST_RING_FULL    = 3'd4
    } status_t;

endpackage

### design/fta_if.sv
interface fta_cmd_if #(
    parameter int FRAME_W   = $clog2(fta_pkg::DEFAULT_MAX_FRAMES),
    parameter int PAGE_BITS = fta_pkg::DEFAULT_PAGE_BITS,
    parameter int SLOT_BITS = fta_pkg::DEFAULT_SLOT_BITS
);
    import fta_pkg::*;

    logic                 valid;
    logic                 ready;
    cmd_t                 cmd;
    logic [FRAME_W-1:0]   frame_index;
    logic [PAGE_BITS-1:0] virtual_page;
    logic [SLOT_BITS-1:0] directory_slot;
    logic [SLOT_BITS-1:0] table_slot;

    modport source (
        output valid, cmd, frame_index, virtual_page, directory_slot, table_slot,
        input  ready
    );
    modport sink (
        input  valid, cmd, frame_index, virtual_page, directory_slot, table_slot,
        output ready
    );
endinterface

interface fta_rsp_if #(
    parameter int FRAME_W   = $clog2(fta_pkg::DEFAULT_MAX_FRAMES),
    parameter int CNT_W     = $clog2(fta_pkg::DEFAULT_MAX_FRAMES + 1),
    parameter int PAGE_BITS = fta_pkg::DEFAULT_PAGE_BITS,
    parameter int SLOT_BITS = fta_pkg::DEFAULT_SLOT_BITS
);
    import fta_pkg::*;

    logic                 valid;
    logic                 ready;
    status_t              status;
    logic [FRAME_W-1:0]   frame_out;
    logic                 entry_allocated;
    logic [PAGE_BITS-1:0] entry_page;
    logic [SLOT_BITS-1:0] entry_directory;
    logic [SLOT_BITS-1:0] entry_table;
    logic [CNT_W-1:0]     free_count;

    modport source (
        output valid, status, frame_out, entry_allocated, entry_page, entry_directory,
               entry_table, free_count,
        input  ready
    );
    modport sink (
        input  valid, status, frame_out, entry_allocated, entry_page, entry_directory,
               entry_table, free_count,
        output ready
    );
endinterface

interface fta_cfg_if #(
    parameter int CNT_W = $clog2(fta_pkg::DEFAULT_MAX_FRAMES + 1)
);
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] frames_in_use;

    modport source (
        output valid, frames_in_use,
        input  ready
    );
    modport sink (
        input  valid, frames_in_use,
        output ready
    );
endinterface

### design/frame_table_allocator_top.sv
// physical frame table with a first-in first-out ring of free frame numbers
// req: one command transaction (allocate, map, free, query) with owner fields
// rsp: one result transaction per command: status, frame, entry view, free count
// cfg: frames_in_use write; reinitialises table and ring in the same cycle, always ready;
//      the user is to issue it only while no command is in flight; the block does not enforce this
// a command passes from the input register to the result register, which drives rsp
// throughput: one command per cycle while rsp does not stall; the ring head value is prefetched from the
//      ring memory into a register every cycle, with bypass of a same-cycle push
// a result register parts the two sides: a command is accepted while the
//      previous result waits; when rsp stalls, one command waits in the input
//      register and req ready drops
// reset: all entries free, ring holds frames 0 to count-1, count is 256 clamped
//      to the number of frames; ring contents are tracked by a fill count, so
//      there is no clearing pass and the block is ready right after reset
module frame_table_allocator_top #(
    parameter int MAX_FRAMES = fta_pkg::DEFAULT_MAX_FRAMES,
    parameter int PAGE_BITS  = fta_pkg::DEFAULT_PAGE_BITS,
    parameter int SLOT_BITS  = fta_pkg::DEFAULT_SLOT_BITS
) (
    input logic        clk,
    input logic        rst_n,
    fta_cmd_if.sink    req,
    fta_rsp_if.source  rsp,
    fta_cfg_if.sink    cfg
);
    import fta_pkg::*;

    localparam int FRAME_W      = $clog2(MAX_FRAMES);
    localparam int CNT_W        = $clog2(MAX_FRAMES + 1);
    localparam int PAY_W        = PAGE_BITS + 2 * SLOT_BITS;
    localparam int START_FRAMES = (RESET_FRAMES < MAX_FRAMES) ? RESET_FRAMES : MAX_FRAMES;
    localparam logic [CNT_W-1:0]   FULL_COUNT  = CNT_W'(MAX_FRAMES);
    localparam logic [CNT_W-1:0]   START_COUNT = CNT_W'(START_FRAMES);
    localparam logic [FRAME_W-1:0] LAST_POS    = FRAME_W'(MAX_FRAMES - 1);
    localparam logic [FRAME_W-1:0] START_TAIL  =
        (START_FRAMES == MAX_FRAMES) ? '0 : FRAME_W'(START_FRAMES);

    function automatic logic [FRAME_W-1:0] ring_next(input logic [FRAME_W-1:0] pos);
        return (pos == LAST_POS) ? '0 : pos + 1'b1;
    endfunction

    // memories
    logic [PAY_W-1:0]   entry_mem [MAX_FRAMES];
    logic [FRAME_W-1:0] ring_mem  [MAX_FRAMES];

    // input stage
    logic                 v_reg, v_next;
    cmd_t                 cmd_reg;
    logic [FRAME_W-1:0]   idx_reg;
    logic [PAGE_BITS-1:0] page_reg;
    logic [SLOT_BITS-1:0] dir_reg;
    logic [SLOT_BITS-1:0] tab_reg;
    logic [PAY_W-1:0]     pay_q_reg;
    logic [PAY_W-1:0]     pay_byp_reg;
    logic                 pay_byp_v_reg, pay_byp_v_next;

    // table and ring state
    logic [MAX_FRAMES-1:0] used_reg, used_next;
    logic [FRAME_W-1:0]    head_reg, head_next;
    logic [FRAME_W-1:0]    tail_reg, tail_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      lim_reg, lim_next;
    logic [CNT_W-1:0]      ovr_reg, ovr_next;
    logic [FRAME_W-1:0]    head_q_reg;
    logic [FRAME_W-1:0]    head_byp_reg;
    logic                  head_byp_v_reg, head_byp_v_next;
    logic                  head_init_reg, head_init_next;

    // result stage
    logic                 ov_reg, ov_next;
    status_t              status_reg;
    logic [FRAME_W-1:0]   frame_reg;
    logic                 alloc_reg;
    logic [PAGE_BITS-1:0] epage_reg;
    logic [SLOT_BITS-1:0] edir_reg;
    logic [SLOT_BITS-1:0] etab_reg;
    logic [CNT_W-1:0]     fcount_reg;

    logic                 fire, in_ready, accept, cfg_wr;
    logic [FRAME_W-1:0]   head_val;
    logic [PAY_W-1:0]     stored;
    logic [PAY_W-1:0]     owner;
    logic                 in_range;
    logic [CNT_W-1:0]     cfg_count;

    status_t              st_res;
    logic [FRAME_W-1:0]   frame_res;
    logic                 alloc_res;
    logic [PAY_W-1:0]     shown_res;
    logic                 wr_entry, push, pop;
    logic [FRAME_W-1:0]   wr_addr;
    logic                 do_wr, do_push, do_pop;

    assign fire     = v_reg && (!ov_reg || rsp.ready);
    assign in_ready = !v_reg || fire;
    assign req.ready = in_ready;
    assign accept   = req.valid && in_ready;
    assign cfg.ready = 1'b1;
    assign cfg_wr   = cfg.valid;

    assign head_val = head_byp_v_reg ? head_byp_reg : (head_init_reg ? head_reg : head_q_reg);
    assign stored   = pay_byp_v_reg ? pay_byp_reg : pay_q_reg;
    assign owner    = {page_reg, dir_reg, tab_reg};
    assign in_range = CNT_W'(idx_reg) < lim_reg;

    always_comb
    begin
        if (cfg.frames_in_use == '0)
        begin
            cfg_count = CNT_W'(1);
        end
        else if (cfg.frames_in_use > FULL_COUNT)
        begin
            cfg_count = FULL_COUNT;
        end
        else
        begin
            cfg_count = cfg.frames_in_use;
        end
    end

    // command evaluation
    always_comb
    begin
        st_res    = ST_OK;
        frame_res = idx_reg;
        alloc_res = 1'b0;
        shown_res = '0;
        wr_entry  = 1'b0;
        wr_addr   = idx_reg;
        push      = 1'b0;
        pop       = 1'b0;
        if (cmd_reg == CMD_ALLOC)
        begin
            if (count_reg == '0)
            begin
                st_res    = ST_NO_FREE;
                frame_res = '0;
            end
            else
            begin
                frame_res = head_val;
                wr_addr   = head_val;
                wr_entry  = 1'b1;
                pop       = 1'b1;
                alloc_res = 1'b1;
                shown_res = owner;
            end
        end
        else if (!in_range)
        begin
            st_res = ST_RANGE;
        end
        else
        begin
            case (cmd_reg)
                CMD_MAP:
                begin
                    wr_entry  = 1'b1;
                    alloc_res = 1'b1;
                    shown_res = owner;
                end
                CMD_FREE:
                begin
                    if (!used_reg[idx_reg])
                    begin
                        st_res = ST_ALREADY_FREE;
                    end
                    else if (count_reg == FULL_COUNT)
                    begin
                        st_res    = ST_RING_FULL;
                        alloc_res = 1'b1;
                        shown_res = stored;
                    end
                    else
                    begin
                        push = 1'b1;
                    end
                end
                CMD_QUERY:
                begin
                    alloc_res = used_reg[idx_reg];
                    shown_res = used_reg[idx_reg] ? stored : '0;
                end
                default:
                begin
                    st_res = ST_OK;
                end
            endcase
        end
    end

    assign do_wr   = fire && wr_entry;
    assign do_push = fire && push;
    assign do_pop  = fire && pop;

    // state update
    always_comb
    begin
        used_next       = used_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        lim_next        = lim_reg;
        ovr_next        = ovr_reg;
        head_byp_v_next = 1'b0;
        if (cfg_wr)
        begin
            used_next  = '0;
            head_next  = '0;
            tail_next  = (cfg_count == FULL_COUNT) ? '0 : cfg_count[FRAME_W-1:0];
            count_next = cfg_count;
            lim_next   = cfg_count;
            ovr_next   = '0;
        end
        else
        begin
            if (do_wr)
            begin
                used_next[wr_addr] = 1'b1;
            end
            if (do_push)
            begin
                used_next[idx_reg] = 1'b0;
                tail_next = ring_next(tail_reg);
                // initial frames overwritten in order once the tail wraps
                if (CNT_W'(tail_reg) == ovr_reg && ovr_reg < lim_reg)
                begin
                    ovr_next = ovr_reg + 1'b1;
                end
            end
            if (do_pop)
            begin
                head_next = ring_next(head_reg);
            end
            count_next = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
            head_byp_v_next = do_push && (tail_reg == head_next);
        end
        head_init_next = (CNT_W'(head_next) >= ovr_next) && (CNT_W'(head_next) < lim_next);
    end

    always_comb
    begin
        v_next         = accept ? 1'b1 : (fire ? 1'b0 : v_reg);
        ov_next        = fire ? 1'b1 : (rsp.ready ? 1'b0 : ov_reg);
        pay_byp_v_next = accept ? (do_wr && (wr_addr == req.frame_index)) : pay_byp_v_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg          <= 1'b0;
            ov_reg         <= 1'b0;
            pay_byp_v_reg  <= 1'b0;
            used_reg       <= '0;
            head_reg       <= '0;
            tail_reg       <= START_TAIL;
            count_reg      <= START_COUNT;
            lim_reg        <= START_COUNT;
            ovr_reg        <= '0;
            head_byp_v_reg <= 1'b0;
            head_init_reg  <= 1'b1;
        end
        else
        begin
            v_reg          <= v_next;
            ov_reg         <= ov_next;
            pay_byp_v_reg  <= pay_byp_v_next;
            used_reg       <= used_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            count_reg      <= count_next;
            lim_reg        <= lim_next;
            ovr_reg        <= ovr_next;
            head_byp_v_reg <= head_byp_v_next;
            head_init_reg  <= head_init_next;
        end
    end

    // input register and entry payload read
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_mem[wr_addr] <= owner;
        end
        if (accept)
        begin
            cmd_reg     <= req.cmd;
            idx_reg     <= req.frame_index;
            page_reg    <= req.virtual_page;
            dir_reg     <= req.directory_slot;
            tab_reg     <= req.table_slot;
            pay_q_reg   <= entry_mem[req.frame_index];
            pay_byp_reg <= owner;
        end
    end

    // free ring with head prefetch
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            ring_mem[tail_reg] <= idx_reg;
        end
        head_q_reg   <= ring_mem[head_next];
        head_byp_reg <= idx_reg;
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            status_reg <= st_res;
            frame_reg  <= frame_res;
            alloc_reg  <= alloc_res;
            epage_reg  <= shown_res[PAY_W-1 -: PAGE_BITS];
            edir_reg   <= shown_res[2*SLOT_BITS-1 -: SLOT_BITS];
            etab_reg   <= shown_res[SLOT_BITS-1:0];
            fcount_reg <= count_next;
        end
    end

    assign rsp.valid           = ov_reg;
    assign rsp.status          = status_reg;
    assign rsp.frame_out       = frame_reg;
    assign rsp.entry_allocated = alloc_reg;
    assign rsp.entry_page      = epage_reg;
    assign rsp.entry_directory = edir_reg;
    assign rsp.entry_table     = etab_reg;
    assign rsp.free_count      = fcount_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT && ovr_reg <= lim_reg)
        else $error("ring count or fill count out of bounds");

    a_alloc_pops: assert property (@(posedge clk) disable iff (!rst_n)
        fire && cmd_reg == CMD_ALLOC && count_reg != '0 && !cfg_wr
        |=> count_reg == $past(count_reg) - 1'b1)
        else $error("allocate did not pop the ring");

    a_free_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && cmd_reg == CMD_FREE && st_res == ST_OK |=> !used_reg[$past(idx_reg)])
        else $error("freed entry still allocated");

    a_range_empty: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && status_reg == ST_RANGE |-> !alloc_reg && epage_reg == '0)
        else $error("range error shows an entry");

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import fta_pkg::*;

    localparam int FRAME_SLOTS = DEFAULT_MAX_FRAMES;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        cmd_t        op;
        logic [7:0]  frame_index;
        logic [19:0] virtual_page;
        logic [9:0]  directory_slot;
        logic [9:0]  table_slot;
    } frame_cmd_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  frame_out;
        logic        entry_allocated;
        logic [19:0] entry_page;
        logic [9:0]  entry_directory;
        logic [9:0]  entry_table;
        logic [8:0]  free_count;
    } frame_result_t;

    logic clk;
    logic rst_n;

    fta_cmd_if req ();
    fta_rsp_if rsp ();
    fta_cfg_if cfg ();

    frame_table_allocator_top u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    // local copy of the frame table and the free ring
    logic          ent_used [FRAME_SLOTS];
    logic [19:0]   ent_page [FRAME_SLOTS];
    logic [9:0]    ent_dir  [FRAME_SLOTS];
    logic [9:0]    ent_tab  [FRAME_SLOTS];
    logic [7:0]    ring_slot [FRAME_SLOTS];
    logic [7:0]    ring_rd;
    logic [7:0]    ring_wr;
    logic [8:0]    ring_fill;
    logic [8:0]    frame_limit;

    frame_result_t pending_results [$];
    int            error_count;
    int            cycle_count;
    bit            no_idle;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want_v);
        $display("mismatch %s: got %0h expected %0h (cycle %0d)", what, got, want_v,
                 cycle_count);
        error_count++;
    endtask

    function automatic void rebuild_tables(input logic [8:0] value);
        int n;
        n = value;
        if (n < 1)
            n = 1;
        if (n > FRAME_SLOTS)
            n = FRAME_SLOTS;
        frame_limit = n[8:0];
        for (int i = 0; i < FRAME_SLOTS; i++)
        begin
            ent_used[i]  = 1'b0;
            ent_page[i]  = '0;
            ent_dir[i]   = '0;
            ent_tab[i]   = '0;
            ring_slot[i] = (i < n) ? i[7:0] : 8'd0;
        end
        ring_rd   = 8'd0;
        ring_wr   = n[7:0];
        ring_fill = n[8:0];
    endfunction

    function automatic frame_result_t apply_command(input frame_cmd_t c);
        frame_result_t r;
        logic [7:0]    f;
        logic          show;
        r        = '0;
        r.status = ST_OK;
        f        = c.frame_index;
        show     = 1'b0;
        if (c.op == CMD_ALLOC)
        begin
            if (ring_fill == 0)
            begin
                r.status = ST_NO_FREE;
                f        = 8'd0;
            end
            else
            begin
                f           = ring_slot[ring_rd];
                ring_rd     = ring_rd + 8'd1;
                ring_fill   = ring_fill - 9'd1;
                ent_used[f] = 1'b1;
                ent_page[f] = c.virtual_page;
                ent_dir[f]  = c.directory_slot;
                ent_tab[f]  = c.table_slot;
                show        = 1'b1;
            end
        end
        else if ({1'b0, c.frame_index} >= frame_limit)
        begin
            r.status = ST_RANGE;
        end
        else
        begin
            show = 1'b1;
            case (c.op)
                CMD_MAP:
                begin
                    ent_used[f] = 1'b1;
                    ent_page[f] = c.virtual_page;
                    ent_dir[f]  = c.directory_slot;
                    ent_tab[f]  = c.table_slot;
                end
                CMD_FREE:
                begin
                    if (!ent_used[f])
                        r.status = ST_ALREADY_FREE;
                    else if (ring_fill >= FRAME_SLOTS)
                        r.status = ST_RING_FULL;
                    else
                    begin
                        ent_used[f]        = 1'b0;
                        ent_page[f]        = '0;
                        ent_dir[f]         = '0;
                        ent_tab[f]         = '0;
                        ring_slot[ring_wr] = f;
                        ring_wr            = ring_wr + 8'd1;
                        ring_fill          = ring_fill + 9'd1;
                    end
                end
                default:
                begin
                end
            endcase
        end
        r.frame_out = f;
        if (show)
        begin
            r.entry_allocated = ent_used[f];
            r.entry_page      = ent_page[f];
            r.entry_directory = ent_dir[f];
            r.entry_table     = ent_tab[f];
        end
        r.free_count = ring_fill;
        return r;
    endfunction

    function automatic frame_cmd_t make_cmd(input cmd_t op, input logic [7:0] idx,
                                            input logic [19:0] pg, input logic [9:0] ds,
                                            input logic [9:0] ts);
        frame_cmd_t c;
        c.op             = op;
        c.frame_index    = idx;
        c.virtual_page   = pg;
        c.directory_slot = ds;
        c.table_slot     = ts;
        return c;
    endfunction

    function automatic int idle_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // called at a falling edge, returns at the falling edge after the transaction
    task automatic send_command(input frame_cmd_t c);
        int gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            req.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req.cmd            = c.op;
        req.frame_index    = c.frame_index;
        req.virtual_page   = c.virtual_page;
        req.directory_slot = c.directory_slot;
        req.table_slot     = c.table_slot;
        req.valid          = 1'b1;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        pending_results.push_back(apply_command(c));
        @(negedge clk);
    endtask

    task automatic settle();
        req.valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_frames_in_use(input logic [8:0] value);
        settle();
        cfg.frames_in_use = value;
        cfg.valid         = 1'b1;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        rebuild_tables(value);
        @(negedge clk);
        cfg.valid = 1'b0;
    endtask

    function automatic logic [19:0] random_page();
        case ($urandom_range(0, 9))
            0:       return 20'hFFFFF;
            1:       return 20'h00000;
            default: return 20'($urandom_range(0, 20'hFFFFF));
        endcase
    endfunction

    function automatic logic [9:0] random_slot();
        case ($urandom_range(0, 9))
            0:       return 10'h3FF;
            1:       return 10'h000;
            default: return 10'($urandom_range(0, 10'h3FF));
        endcase
    endfunction

    function automatic frame_cmd_t random_command();
        frame_cmd_t c;
        int         r;
        logic [7:0] idx;
        r = $urandom_range(0, 99);
        if (r < 35)
            c.op = CMD_ALLOC;
        else if (r < 50)
            c.op = CMD_MAP;
        else if (r < 80)
            c.op = CMD_FREE;
        else
            c.op = CMD_QUERY;
        if ($urandom_range(0, 4) == 0)
            idx = 8'($urandom_range(0, 255));
        else
            idx = 8'($urandom_range(0, frame_limit - 1));
        // frees mostly aim at a frame that is currently owned
        if (c.op == CMD_FREE && $urandom_range(0, 9) < 7)
        begin
            for (int k = 0; k < 16; k++)
            begin
                idx = 8'($urandom_range(0, frame_limit - 1));
                if (ent_used[idx])
                    break;
            end
        end
        c.frame_index    = idx;
        c.virtual_page   = random_page();
        c.directory_slot = random_slot();
        c.table_slot     = random_slot();
        return c;
    endfunction

    initial
    begin
        int hold;
        int r;
        rsp.ready = 1'b0;
        hold      = 0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
                hold--;
            else if (no_idle)
                rsp.ready = 1'b1;
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 65)
                begin
                    rsp.ready = 1'b1;
                    hold      = $urandom_range(1, 8);
                end
                else if (r < 93)
                begin
                    rsp.ready = 1'b0;
                    hold      = $urandom_range(1, 3);
                end
                else
                begin
                    rsp.ready = 1'b0;
                    hold      = $urandom_range(10, 30);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        frame_result_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with nothing expected", 32'(rsp.frame_out), 32'd0);
            else
            begin
                want = pending_results.pop_front();
                if (rsp.status !== want.status)
                    report_mismatch("status", 32'(rsp.status), 32'(want.status));
                if (rsp.frame_out !== want.frame_out)
                    report_mismatch("frame_out", 32'(rsp.frame_out), 32'(want.frame_out));
                if (rsp.entry_allocated !== want.entry_allocated)
                    report_mismatch("entry_allocated", 32'(rsp.entry_allocated),
                                    32'(want.entry_allocated));
                if (rsp.entry_page !== want.entry_page)
                    report_mismatch("entry_page", 32'(rsp.entry_page), 32'(want.entry_page));
                if (rsp.entry_directory !== want.entry_directory)
                    report_mismatch("entry_directory", 32'(rsp.entry_directory),
                                    32'(want.entry_directory));
                if (rsp.entry_table !== want.entry_table)
                    report_mismatch("entry_table", 32'(rsp.entry_table),
                                    32'(want.entry_table));
                if (rsp.free_count !== want.free_count)
                    report_mismatch("free_count", 32'(rsp.free_count),
                                    32'(want.free_count));
            end
        end
    end

    task automatic test_reset_state();
        send_command(make_cmd(CMD_QUERY, 8'd0, 20'h0, 10'h0, 10'h0));
        send_command(make_cmd(CMD_QUERY, 8'd255, 20'h0, 10'h0, 10'h0));
        send_command(make_cmd(CMD_ALLOC, 8'd0, 20'hFFFFF, 10'h3FF, 10'h3FF));
        send_command(make_cmd(CMD_ALLOC, 8'd255, 20'h00000, 10'h000, 10'h000));
        send_command(make_cmd(CMD_QUERY, 8'd0, 20'h0, 10'h0, 10'h0));
        send_command(make_cmd(CMD_FREE, 8'd0, 20'h0, 10'h0, 10'h0));
        send_command(make_cmd(CMD_FREE, 8'd0, 20'h0, 10'h0, 10'h0));
        send_command(make_cmd(CMD_MAP, 8'd255, 20'hFFFFF, 10'h3FF, 10'h3FF));
        send_command(make_cmd(CMD_QUERY, 8'd255, 20'h0, 10'h0, 10'h0));
    endtask

    // mapped frame still sitting in the ring, then free into a full ring
    task automatic test_ring_full();
        write_frames_in_use(9'd256);
        send_command(make_cmd(CMD_MAP, 8'd7, 20'h12345, 10'h155, 10'h2AA));
        send_command(make_cmd(CMD_FREE, 8'd7, 20'h0, 10'h0, 10'h0));
        send_command(make_cmd(CMD_MAP, 8'd0, 20'hABCDE, 10'h0F0, 10'h30F));
        send_command(make_cmd(CMD_ALLOC, 8'd0, 20'h54321, 10'h2AA, 10'h155));
        send_command(make_cmd(CMD_QUERY, 8'd0, 20'h0, 10'h0, 10'h0));
    endtask

    // zero count is taken as one frame
    task automatic test_empty_ring();
        write_frames_in_use(9'd0);
        send_command(make_cmd(CMD_ALLOC, 8'd0, 20'h0F0F0, 10'h111, 10'h222));
        send_command(make_cmd(CMD_ALLOC, 8'd0, 20'h0F0F0, 10'h111, 10'h222));
        send_command(make_cmd(CMD_QUERY, 8'd1, 20'h0, 10'h0, 10'h0));
        send_command(make_cmd(CMD_FREE, 8'd255, 20'h0, 10'h0, 10'h0));
        send_command(make_cmd(CMD_FREE, 8'd0, 20'h0, 10'h0, 10'h0));
        send_command(make_cmd(CMD_FREE, 8'd0, 20'h0, 10'h0, 10'h0));
        send_command(make_cmd(CMD_ALLOC, 8'd0, 20'hFFFFF, 10'h3FF, 10'h3FF));
    endtask

    // counts above the table size are clamped
    task automatic test_count_clamp();
        write_frames_in_use(9'd511);
        send_command(make_cmd(CMD_QUERY, 8'd255, 20'h0, 10'h0, 10'h0));
        send_command(make_cmd(CMD_MAP, 8'd200, 20'h00001, 10'h001, 10'h001));
    endtask

    task automatic test_back_to_back();
        no_idle = 1'b1;
        write_frames_in_use(9'd4);
        repeat (40) send_command(random_command());
        settle();
        no_idle = 1'b0;
    endtask

    task automatic test_random_traffic();
        logic [8:0] counts [8];
        counts[0] = 9'd2;
        counts[1] = 9'd16;
        counts[2] = 9'd256;
        counts[3] = 9'($urandom_range(1, 256));
        counts[4] = 9'd1;
        counts[5] = 9'd511;
        counts[6] = 9'($urandom_range(0, 511));
        counts[7] = 9'd64;
        for (int p = 0; p < 8; p++)
        begin
            write_frames_in_use(counts[p]);
            repeat (80) send_command(random_command());
        end
        settle();
    endtask

    initial
    begin
        error_count        = 0;
        cycle_count        = 0;
        no_idle            = 1'b0;
        rst_n              = 1'b0;
        req.valid          = 1'b0;
        req.cmd            = CMD_ALLOC;
        req.frame_index    = '0;
        req.virtual_page   = '0;
        req.directory_slot = '0;
        req.table_slot     = '0;
        cfg.valid          = 1'b0;
        cfg.frames_in_use  = '0;
        rebuild_tables(9'(RESET_FRAMES));
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        test_reset_state();
        test_ring_full();
        test_empty_ring();
        test_count_clamp();
        test_back_to_back();
        test_random_traffic();

        settle();
        repeat (4) @(negedge clk);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
